// File: hw/rtl/rhfdp_pkg.sv
// shared constants, types and tables for the relative humidity pipeline
package rhfdp_pkg;

  localparam int unsigned NumW     = 57;
  localparam int unsigned DenW     = 29;
  localparam int unsigned QuotW    = 30;
  localparam int unsigned NumTerms = 12;

  localparam logic [22:0] DEW_T0   = 23'd1748224;
  localparam logic [22:0] DEW_A4   = 23'd206016;
  localparam logic [22:0] TEMP_OFF = 23'd1542208;
  localparam logic [13:0] A3_NUM   = 14'd8751;
  localparam logic [6:0]  A3_DEN1  = 7'd125;
  localparam logic [2:0]  A3_DEN2  = 3'd5;

  localparam logic signed [31:0] X_HIGH = 32'sd16777216;
  localparam logic signed [31:0] X_LOW  = -32'sd218103808;
  localparam logic signed [28:0] XO_OFF = 29'sd220952520;
  localparam logic [23:0] LN2       = 24'd11629080;
  localparam logic [16:0] LN2_RECIP = 17'd94548;
  localparam logic [30:0] TERM_ONE  = 31'h4000_0000;
  localparam logic [16:0] RH_MAX    = 17'h1_FFFF;

  typedef struct packed {
    logic                    ovf;
    logic                    neg;
    logic signed [QuotW:0]   quot;
  } rhfdp_quot_t;

  typedef struct packed {
    logic        big;
    logic        tiny;
    logic [4:0]  kp;
    logic [29:0] r30;
    logic [32:0] sum;
  } rhfdp_series_t;

  typedef struct packed {
    logic        saturated;
    logic [16:0] rh_frac;
  } rhfdp_result_t;

  // floor(2^30 / k) for the series term divisors
  function automatic logic [30:0] term_recip(input int unsigned k);
    logic [30:0] r;
    case (k)
      1:       r = 31'd1073741824;
      2:       r = 31'd536870912;
      3:       r = 31'd357913941;
      4:       r = 31'd268435456;
      5:       r = 31'd214748364;
      6:       r = 31'd178956970;
      7:       r = 31'd153391689;
      8:       r = 31'd134217728;
      9:       r = 31'd119304647;
      10:      r = 31'd107374182;
      11:      r = 31'd97612893;
      12:      r = 31'd89478485;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/rhfdp_div.sv
// pipelined restoring divider, one quotient bit per stage, floor of signed ratio
module rhfdp_div
  import rhfdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NumW-1:0]   num,
  input  logic [DenW-1:0]   den,
  input  logic              neg,
  output logic              out_valid,
  output rhfdp_quot_t       out_quot
);

  logic             stg_valid [QuotW+1];
  logic [DenW-1:0]  stg_rem   [QuotW+1];
  logic [QuotW-1:0] stg_low   [QuotW+1];
  logic [QuotW-1:0] stg_quot  [QuotW+1];
  logic [DenW-1:0]  stg_den   [QuotW+1];
  logic             stg_neg   [QuotW+1];
  logic             stg_ovf   [QuotW+1];

  logic [DenW-1:0]  num_high;
  logic [QuotW:0]   mag;

  assign num_high = DenW'(num[NumW-1:QuotW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (en) begin
      stg_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_rem[0]  <= num_high;
      stg_low[0]  <= num[QuotW-1:0];
      stg_quot[0] <= '0;
      stg_den[0]  <= den;
      stg_neg[0]  <= neg;
      stg_ovf[0]  <= num_high >= den;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [DenW:0] cand;
    logic [DenW:0] diff;
    logic          ge;

    assign cand = {stg_rem[k], stg_low[k][QuotW-1]};
    assign diff = cand - {1'b0, stg_den[k]};
    assign ge   = cand >= {1'b0, stg_den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k+1] <= 1'b0;
      end else if (en) begin
        stg_valid[k+1] <= stg_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_rem[k+1]  <= ge ? diff[DenW-1:0] : cand[DenW-1:0];
        stg_low[k+1]  <= stg_low[k] << 1;
        stg_quot[k+1] <= {stg_quot[k][QuotW-2:0], ge};
        stg_den[k+1]  <= stg_den[k];
        stg_neg[k+1]  <= stg_neg[k];
        stg_ovf[k+1]  <= stg_ovf[k];
      end
    end
  end

  // negative ratios round toward minus infinity
  assign mag = {1'b0, stg_quot[QuotW]} + (QuotW+1)'(|stg_rem[QuotW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= stg_valid[QuotW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quot.ovf  <= stg_ovf[QuotW];
      out_quot.neg  <= stg_neg[QuotW];
      out_quot.quot <= stg_neg[QuotW] ? -$signed(mag) : $signed({1'b0, stg_quot[QuotW]});
    end
  end

endmodule

// File: hw/rtl/rhfdp_exp.sv
// pipelined exponential: range reduction by ln 2, series sum, rounding and clamp
module rhfdp_exp
  import rhfdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [28:0] x,
  input  logic               big,
  input  logic               tiny,
  output logic               out_valid,
  output rhfdp_result_t      out_result
);

  logic        e0_valid, e1_valid, e2_valid;
  logic [27:0] e0_xo, e1_xo;
  logic [4:0]  e1_kq, e2_kq;
  logic [24:0] e2_r0;
  logic        e0_big, e0_tiny, e1_big, e1_tiny, e2_big, e2_tiny;

  logic [28:0] xo_sum;
  logic [44:0] recip_prod;
  logic [27:0] r0_wide;
  logic        r0_ge;
  logic [24:0] r_red;

  logic           tc_valid [NumTerms+1];
  rhfdp_series_t  tc_ser   [NumTerms+1];
  logic [30:0]    tc_term  [NumTerms+1];

  logic          f1_valid;
  logic          f1_big, f1_tiny;
  logic [20:0]   f1_rh;
  logic [5:0]    shift;
  logic [33:0]   rounded;

  assign xo_sum     = x + XO_OFF;
  assign recip_prod = 45'(e0_xo) * 45'(LN2_RECIP);
  assign r0_wide    = e1_xo - 28'(28'(e1_kq) * 28'(LN2));
  assign r0_ge      = e2_r0 >= 25'(LN2);
  assign r_red      = r0_ge ? 25'(e2_r0 - 25'(LN2)) : e2_r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_valid    <= 1'b0;
      e1_valid    <= 1'b0;
      e2_valid    <= 1'b0;
      tc_valid[0] <= 1'b0;
    end else if (en) begin
      e0_valid    <= in_valid;
      e1_valid    <= e0_valid;
      e2_valid    <= e1_valid;
      tc_valid[0] <= e2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_xo          <= xo_sum[27:0];
      e0_big         <= big;
      e0_tiny        <= tiny;
      e1_xo          <= e0_xo;
      e1_kq          <= recip_prod[44:40];
      e1_big         <= e0_big;
      e1_tiny        <= e0_tiny;
      e2_r0          <= r0_wide[24:0];
      e2_kq          <= e1_kq;
      e2_big         <= e1_big;
      e2_tiny        <= e1_tiny;
      tc_ser[0].big  <= e2_big;
      tc_ser[0].tiny <= e2_tiny;
      tc_ser[0].kp   <= r0_ge ? e2_kq + 5'd1 : e2_kq;
      tc_ser[0].r30  <= {r_red[23:0], 6'd0};
      tc_ser[0].sum  <= 33'(TERM_ONE);
      tc_term[0]     <= TERM_ONE;
    end
  end

  for (genvar gi = 0; gi < NumTerms; gi++) begin : g_term
    localparam logic [30:0] Recip = term_recip(gi + 1);
    localparam logic [29:0] Div   = 30'(gi + 1);

    logic          ta_valid, tb_valid;
    rhfdp_series_t ta_ser, tb_ser;
    logic [29:0]   ta_v, tb_v, tb_e;
    logic [60:0]   pw_prod;
    logic [60:0]   dv_prod;
    logic [29:0]   rr;
    logic [29:0]   t_new;

    assign pw_prod = 61'(tc_term[gi]) * 61'(tc_ser[gi].r30);
    assign dv_prod = 61'(ta_v) * 61'(Recip);
    assign rr      = tb_v - 30'(tb_e * Div);
    assign t_new   = tb_e + 30'(rr >= Div);

    always_ff @(posedge clk) begin
      if (rst) begin
        ta_valid       <= 1'b0;
        tb_valid       <= 1'b0;
        tc_valid[gi+1] <= 1'b0;
      end else if (en) begin
        ta_valid       <= tc_valid[gi];
        tb_valid       <= ta_valid;
        tc_valid[gi+1] <= tb_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ta_v               <= pw_prod[59:30];
        ta_ser             <= tc_ser[gi];
        tb_v               <= ta_v;
        tb_e               <= dv_prod[59:30];
        tb_ser             <= ta_ser;
        tc_term[gi+1]      <= {1'b0, t_new};
        tc_ser[gi+1].big   <= tb_ser.big;
        tc_ser[gi+1].tiny  <= tb_ser.tiny;
        tc_ser[gi+1].kp    <= tb_ser.kp;
        tc_ser[gi+1].r30   <= tb_ser.r30;
        tc_ser[gi+1].sum   <= tb_ser.sum + 33'(t_new);
      end
    end
  end

  // scale from Q30 to Q16 by 2^(kp-19), rounding half up
  assign shift   = 6'd33 - {1'b0, tc_ser[NumTerms].kp};
  assign rounded = {1'b0, tc_ser[NumTerms].sum} + (34'd1 << (shift - 6'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_valid  <= tc_valid[NumTerms];
      out_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_rh   <= 21'(rounded >> shift);
      f1_big  <= tc_ser[NumTerms].big;
      f1_tiny <= tc_ser[NumTerms].tiny;
      if (f1_big) begin
        out_result.rh_frac   <= RH_MAX;
        out_result.saturated <= 1'b1;
      end else if (f1_tiny) begin
        out_result.rh_frac   <= '0;
        out_result.saturated <= 1'b0;
      end else if (f1_rh > 21'(RH_MAX)) begin
        out_result.rh_frac   <= RH_MAX;
        out_result.saturated <= 1'b1;
      end else begin
        out_result.rh_frac   <= f1_rh[16:0];
        out_result.saturated <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/rhfdp_skid.sv
// two-entry output buffer that decouples the pipeline stall from the consumer
module rhfdp_skid
  import rhfdp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rhfdp_result_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rhfdp_result_t out_data
);

  logic          skid_valid;
  rhfdp_result_t skid_data;
  logic          in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= in_data;
      end
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: hw/rtl/relative_humidity_from_dew_point.sv
// relative humidity from air temperature and dew point, top level
// throughput: one request per cycle while the output skid entry is free, set by the
// fully pipelined dividers and series
// the pipeline freezes only while the output skid entry is occupied
// rst is synchronous: clears all valid bits and the output buffer, data is left as is
module relative_humidity_from_dew_point
  import rhfdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // air_temp [15:0], dew_point [32:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // rel_humidity [16:0]
  output logic        m_tuser    // saturated [0]
);

  logic en;

  logic               st0_valid;
  logic signed [15:0] st0_temp;
  logic [16:0]        st0_dew;

  logic               st1_valid;
  logic [21:0]        st1_a_mag, st1_b_mag, st1_c;
  logic [15:0]        st1_t_mag;
  logic               st1_neg1, st1_neg2;

  logic [21:0]        td25;
  logic signed [22:0] a_d, b_d, t_ext, t25, c_d;

  logic [35:0]        a_prod;
  logic [29:0]        t_prod;
  logic [NumW-1:0]    num1, num2;
  logic [DenW-1:0]    den1, den2;

  logic               d1_valid, d2_valid;
  rhfdp_quot_t        d1_quot, d2_quot;

  logic signed [31:0] x_d;
  logic               big_d, tiny_d;
  logic               cb_valid;
  logic signed [28:0] cb_x;
  logic               cb_big, cb_tiny;

  logic               ex_valid;
  rhfdp_result_t      ex_result, out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      st0_valid <= 1'b0;
      st1_valid <= 1'b0;
      cb_valid  <= 1'b0;
    end else if (en) begin
      st0_valid <= s_tvalid;
      st1_valid <= st0_valid;
      cb_valid  <= d1_valid && d2_valid;
    end
  end

  assign td25  = 22'(st0_dew) * 22'd25;
  assign a_d   = $signed({1'b0, td25}) - $signed(DEW_T0);
  assign b_d   = $signed({1'b0, td25}) - $signed(DEW_A4);
  assign t_ext = 23'(st0_temp);
  assign t25   = t_ext * 23'sd25;
  assign c_d   = t25 + $signed(TEMP_OFF);

  always_ff @(posedge clk) begin
    if (en) begin
      st0_temp  <= $signed(s_tdata[15:0]);
      st0_dew   <= s_tdata[32:16];
      st1_a_mag <= a_d[22] ? 22'(-a_d) : a_d[21:0];
      st1_b_mag <= b_d[22] ? 22'(-b_d) : b_d[21:0];
      st1_neg1  <= a_d[22] ^ b_d[22];
      st1_c     <= c_d[21:0];
      st1_t_mag <= st0_temp[15] ? 16'(-st0_temp) : 16'(st0_temp);
      st1_neg2  <= st0_temp[15];
    end
  end

  assign a_prod = 36'(st1_a_mag) * 36'(A3_NUM);
  assign t_prod = 30'(st1_t_mag) * 30'(A3_NUM);
  assign num1   = {a_prod[34:0], 22'd0};
  assign num2   = {5'd0, t_prod, 22'd0};
  assign den1   = DenW'(st1_b_mag) * DenW'(A3_DEN1);
  assign den2   = DenW'(st1_c) * DenW'(A3_DEN2);

  rhfdp_div u_div_dew (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (st1_valid),
    .num       (num1),
    .den       (den1),
    .neg       (st1_neg1),
    .out_valid (d1_valid),
    .out_quot  (d1_quot)
  );

  rhfdp_div u_div_air (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (st1_valid),
    .num       (num2),
    .den       (den2),
    .neg       (st1_neg2),
    .out_valid (d2_valid),
    .out_quot  (d2_quot)
  );

  // an overflowed dew term is beyond either exponent limit
  assign x_d    = 32'(d1_quot.quot) - 32'(d2_quot.quot);
  assign big_d  = d1_quot.ovf ? !d1_quot.neg : (x_d > X_HIGH);
  assign tiny_d = d1_quot.ovf ? d1_quot.neg : (x_d < X_LOW);

  always_ff @(posedge clk) begin
    if (en) begin
      cb_x    <= (big_d || tiny_d) ? '0 : x_d[28:0];
      cb_big  <= big_d;
      cb_tiny <= tiny_d && !big_d;
    end
  end

  rhfdp_exp u_exp (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (cb_valid),
    .x          (cb_x),
    .big        (cb_big),
    .tiny       (cb_tiny),
    .out_valid  (ex_valid),
    .out_result (ex_result)
  );

  rhfdp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ex_valid),
    .in_ready  (en),
    .in_data   (ex_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign s_tready = en;
  assign m_tdata  = {7'd0, out_result.rh_frac};
  assign m_tuser  = out_result.saturated;

endmodule

// File: tb/sv/rh_checker.sv
// checker: predicts relative humidity per request and compares with the block output
`timescale 1ns / 100ps
module rh_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  typedef struct packed {
    logic        sat;
    logic [16:0] rh;
  } humidity_t;

  humidity_t expected_rh[$];

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [63:0] exp_fixed(longint x);
    logic [63:0] xo, kp, r, r30, term, sum;
    int s;
    xo = x + 19 * 64'd11629080;
    kp = xo / 64'd11629080;
    r = xo - kp * 64'd11629080;
    r30 = r << 6;
    term = 64'd1 << 30;
    sum = term;
    for (int i = 1; i <= 12; i++) begin
      term = (term * r30) >> 30;
      term = term / i;
      sum = sum + term;
    end
    s = 33 - int'(kp);
    return (sum + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic humidity_t predict_humidity(logic [15:0] t_in, logic [16:0] td_in);
    longint t_u, td_u, num, den, t1, t2, x;
    logic [63:0] v;
    humidity_t res;
    t_u = longint'($signed(t_in)) * 100;
    td_u = longint'(td_in) * 100;
    num = 17502 * (td_u - 6992896) * 64'sd16777216;
    den = 1000 * (td_u - 824064);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    res = '0;
    if (den == 0) begin
      res.rh = 17'h1ffff;
      res.sat = 1'b1;
    end else begin
      t1 = floor_quot(num, den);
      t2 = floor_quot(17502 * t_u * 64'sd16777216, 1000 * (t_u + 6992896 - 824064));
      x = t1 - t2;
      if (x > 64'sd16777216) begin
        res.rh = 17'h1ffff;
        res.sat = 1'b1;
      end else if (x >= -13 * 64'sd16777216) begin
        v = exp_fixed(x);
        if (v > 64'd131071) begin
          res.rh = 17'h1ffff;
          res.sat = 1'b1;
        end else begin
          res.rh = v[16:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    humidity_t want;
    if (rst) begin
      fail_count <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_rh.insert(expected_rh.size(),
                           predict_humidity(s_tdata[15:0], s_tdata[32:16]));
      if (m_tvalid && m_tready) begin
        checked <= checked + 1;
        if (expected_rh.size() == 0) begin
          if (fail_count < 10) $display("unexpected result rh=%0d sat=%0b", m_tdata[16:0], m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rh.pop_front();
          if (want.rh !== m_tdata[16:0] || want.sat !== m_tuser || m_tdata[23:17] !== 7'd0) begin
            if (fail_count < 10)
              $display("mismatch: expected rh=%0d sat=%0b, got data=%h sat=%0b",
                       want.rh, want.sat, m_tdata, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_rh.size();
    end
  end
endmodule

// File: tb/sv/testbench.sv
// testbench top: stimulus, flow control and verdict for the humidity block
`timescale 1ns / 100ps
module testbench;
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  int          fail_count, pending, checked;
  int          cycles;
  logic [15:0] temp_list[$];
  logic [16:0] dew_list[$];

  relative_humidity_from_dew_point dut (.*);

  rh_checker scoreboard (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) cycles <= 0;
    else cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("relative_humidity_from_dew_point verification failed");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int phase;
    phase = (cycles / 64) % 4;
    if (phase == 0) m_tready <= 1'b1;
    else if (phase == 1) m_tready <= ($urandom_range(0, 3) != 0);
    else if (phase == 2) m_tready <= ($urandom_range(0, 1) != 0);
    else m_tready <= ($urandom_range(0, 5) == 0);
  end

  task automatic add_request(logic [15:0] t, logic [16:0] td);
    temp_list.insert(temp_list.size(), t);
    dew_list.insert(dew_list.size(), td);
  endtask

  initial begin
    int burst, gap, idx, hold;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    // extremes of the ranges and of the bit patterns
    add_request(-16'sd25600, 17'd44800);
    add_request(16'sd19200, 17'd89600);
    add_request(-16'sd25600, 17'd89600);
    add_request(16'sd19200, 17'd44800);
    add_request(16'h0000, 17'd69930);
    add_request(16'h0000, 17'd69929);
    add_request(16'h7fff, 17'h1ffff);
    add_request(16'h8000, 17'h00000);
    add_request(16'hffff, 17'h1ffff);
    add_request(16'h8000, 17'h1ffff);
    add_request(16'h7fff, 17'h00000);
    add_request(16'd0, 17'd8046);
    add_request(16'd0, 17'd8047);
    add_request(16'd6400, 17'd65000);
    add_request(16'd6400, 17'd76330);
    add_request(-16'sd6400, 17'd60000);
    add_request(16'd2560, 17'd44800);
    for (int i = 0; i < 1550; i++) begin
      logic [15:0] t;
      logic [16:0] td;
      int mode;
      mode = $urandom_range(0, 9);
      t = 16'($signed($urandom_range(0, 44800)) - 25600);
      if (mode < 5)
        td = 17'(int'($signed(t)) + 69930 - int'($urandom_range(0, 6000)));
      else if (mode < 7)
        td = 17'(int'($signed(t)) + 69930 + int'($urandom_range(0, 300)) - 150);
      else if (mode < 9) td = 17'($urandom_range(44800, 89600));
      else begin
        t = 16'($urandom);
        td = 17'($urandom);
      end
      add_request(t, td);
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    idx = 0;
    while (idx < temp_list.size()) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      while (burst > 0 && idx < temp_list.size()) begin
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, dew_list[idx], temp_list[idx]};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        idx++;
        burst--;
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    hold = 0;
    while (hold < 200) begin
      @(posedge clk);
      hold++;
    end
    $display("sent %0d requests (directed extremes plus random near-saturation and",
             temp_list.size());
    $display("out-of-range points), %0d results checked", checked);
    if (fail_count == 0 && pending == 0)
      $display("relative_humidity_from_dew_point verification clean");
    else
      $display("relative_humidity_from_dew_point verification failed");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/rhfdp_pkg.sv
hw/rtl/rhfdp_div.sv
hw/rtl/rhfdp_exp.sv
hw/rtl/rhfdp_skid.sv
hw/rtl/relative_humidity_from_dew_point.sv
tb/sv/rh_checker.sv
tb/sv/testbench.sv
